/* src/srint_pkg.sv */
`default_nettype none

package srint_pkg;

  // Coordinate width used when the top level is not overridden.
  localparam int COORD_BITS_DEFAULT = 24;

  // Cross-product sign units: four per rectangle diagonal, two diagonals.
  localparam int CROSS_UNITS = 8;

  // Result stream data width: the hit flag padded to one byte.
  localparam int OUT_W = 8;

  // Load enables for the two register stages inside a cross unit.
  typedef struct packed {
    logic prod;
    logic sign;
  } cross_en_t;

  // Sign of one cross product, with zero kept apart from positive.
  typedef struct packed {
    logic neg;
    logic zero;
  } sign_t;

endpackage

`default_nettype wire

/* src/srint_prep.sv */
`default_nettype none

module srint_prep import srint_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEFAULT,
  localparam int OPW = COORD_BITS + 2
) (
  input  logic                         clk,
  input  logic                         en,
  input  logic signed [COORD_BITS-1:0] rect_left,
  input  logic signed [COORD_BITS-1:0] rect_top,
  input  logic        [COORD_BITS-2:0] rect_width,
  input  logic        [COORD_BITS-2:0] rect_height,
  input  logic signed [COORD_BITS-1:0] start_x,
  input  logic signed [COORD_BITS-1:0] start_y,
  input  logic signed [COORD_BITS-1:0] end_x,
  input  logic signed [COORD_BITS-1:0] end_y,
  output logic signed [OPW-1:0]        op_a [CROSS_UNITS],
  output logic signed [OPW-1:0]        op_b [CROSS_UNITS],
  output logic signed [OPW-1:0]        op_c [CROSS_UNITS],
  output logic signed [OPW-1:0]        op_d [CROSS_UNITS],
  output logic                         inside_start,
  output logic                         inside_end
);

  logic signed [OPW-1:0] l, t, w, h, r, b, sx, sy, ex, ey, dx, dy;
  logic signed [OPW-1:0] a_c [CROSS_UNITS];
  logic signed [OPW-1:0] b_c [CROSS_UNITS];
  logic signed [OPW-1:0] c_c [CROSS_UNITS];
  logic signed [OPW-1:0] d_c [CROSS_UNITS];
  logic                  in_s_c, in_e_c;

  // Two guard bits keep right, bottom and every difference exact.
  assign l  = OPW'(rect_left);
  assign t  = OPW'(rect_top);
  assign w  = OPW'(rect_width);
  assign h  = OPW'(rect_height);
  assign sx = OPW'(start_x);
  assign sy = OPW'(start_y);
  assign ex = OPW'(end_x);
  assign ey = OPW'(end_y);
  assign r  = l + w;
  assign b  = t + h;
  assign dx = ex - sx;
  assign dy = ey - sy;

  // Each unit takes the sign of a*b - c*d. Units 0..3 test the diagonal from
  // top left to bottom right, units 4..7 the one from top right to bottom left.
  // Within a diagonal: both segment-side tests first, then both diagonal-side.
  always_comb begin
    a_c[0] = l - sx;  b_c[0] = dy; c_c[0] = t - sy;  d_c[0] = dx;
    a_c[1] = r - sx;  b_c[1] = dy; c_c[1] = b - sy;  d_c[1] = dx;
    a_c[2] = sx - l;  b_c[2] = h;  c_c[2] = sy - t;  d_c[2] = w;
    a_c[3] = ex - l;  b_c[3] = h;  c_c[3] = ey - t;  d_c[3] = w;
    a_c[4] = r - sx;  b_c[4] = dy; c_c[4] = t - sy;  d_c[4] = dx;
    a_c[5] = l - sx;  b_c[5] = dy; c_c[5] = b - sy;  d_c[5] = dx;
    a_c[6] = sx - r;  b_c[6] = h;  c_c[6] = sy - t;  d_c[6] = l - r;
    a_c[7] = ex - r;  b_c[7] = h;  c_c[7] = ey - t;  d_c[7] = l - r;
  end

  assign in_s_c = (sx > l) && (sx < r) && (sy > t) && (sy < b);
  assign in_e_c = (ex > l) && (ex < r) && (ey > t) && (ey < b);

  always_ff @(posedge clk) begin
    if (en) begin
      op_a         <= a_c;
      op_b         <= b_c;
      op_c         <= c_c;
      op_d         <= d_c;
      inside_start <= in_s_c;
      inside_end   <= in_e_c;
    end
  end

endmodule

`default_nettype wire

/* src/srint_cross.sv */
`default_nettype none

module srint_cross import srint_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEFAULT,
  localparam int OPW = COORD_BITS + 2,
  localparam int PW  = 2 * OPW,
  localparam int DW  = PW + 1
) (
  input  logic                  clk,
  input  cross_en_t             en,
  input  logic signed [OPW-1:0] a,
  input  logic signed [OPW-1:0] b,
  input  logic signed [OPW-1:0] c,
  input  logic signed [OPW-1:0] d,
  output sign_t                 sg
);

  logic signed [PW-1:0] p_ab, p_cd;
  logic signed [DW-1:0] diff;

  always_ff @(posedge clk) begin
    if (en.prod) begin
      p_ab <= a * b;
      p_cd <= c * d;
    end
  end

  assign diff = p_ab - p_cd;

  always_ff @(posedge clk) begin
    if (en.sign) begin
      sg.neg  <= diff[DW-1];
      sg.zero <= (diff == '0);
    end
  end

endmodule

`default_nettype wire

/* src/segment_rectangle_intersect.sv */
`default_nettype none

// Segment versus rectangle hit test. Each input item carries an axis-aligned
// rectangle (left, top, width, height) and a segment (start, end point) in
// signed fixed point; the fraction position does not change the answer, so
// the block only needs the total coordinate width. The single result item is
// a hit flag that is set when either endpoint lies strictly inside the
// rectangle or the segment strictly crosses one of the two diagonals; edges
// and collinear touching do not count. All arithmetic is exact, including a
// right or bottom edge that reaches past the coordinate range. The block
// takes one item every clock cycle while the output is not stalled and
// returns results in order. The work runs through a five-stage pipeline:
// input register, differences and inside tests, sixteen parallel
// (COORD_BITS+2)-bit multipliers, product difference and sign, and the
// result register. Each stage holds its own valid bit, so an empty stage
// is filled even while the result register waits to be taken.

module segment_rectangle_intersect import srint_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEFAULT,
  localparam int IN_BITS = 8 * COORD_BITS - 2,
  localparam int IN_W    = ((IN_BITS + 7) / 8) * 8
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            s_tvalid,
  output logic            s_tready,
  // from bit 0 up: rect_left, rect_top, rect_width, rect_height,
  // start_x, start_y, end_x, end_y, zero padding
  input  logic [IN_W-1:0] s_tdata,
  output logic            m_tvalid,
  input  logic            m_tready,
  // from bit 0 up: hit, zero padding
  output logic [OUT_W-1:0] m_tdata
);

  localparam int STAGES = 5;
  localparam int OPW    = COORD_BITS + 2;

  // Field offsets inside tdata.
  localparam int TOP_LO = COORD_BITS;
  localparam int WID_LO = 2 * COORD_BITS;
  localparam int HGT_LO = 3 * COORD_BITS - 1;
  localparam int SX_LO  = 4 * COORD_BITS - 2;
  localparam int SY_LO  = 5 * COORD_BITS - 2;
  localparam int EX_LO  = 6 * COORD_BITS - 2;
  localparam int EY_LO  = 7 * COORD_BITS - 2;

  logic [STAGES-1:0] vld;
  logic [STAGES-1:0] adv;
  logic [IN_BITS-1:0] in_data;

  logic signed [OPW-1:0] op_a [CROSS_UNITS];
  logic signed [OPW-1:0] op_b [CROSS_UNITS];
  logic signed [OPW-1:0] op_c [CROSS_UNITS];
  logic signed [OPW-1:0] op_d [CROSS_UNITS];
  sign_t                 sg   [CROSS_UNITS];
  cross_en_t             cen;

  logic       inside_start, inside_end;
  logic [1:0] inside_p, inside_s;
  logic       cross_main, cross_anti;
  logic       hit;

  // A stage may load when it is empty or when the stage after it moves on.
  always_comb begin
    adv[STAGES-1] = !vld[STAGES-1] || m_tready;
    for (int k = STAGES - 2; k >= 0; k--) begin
      adv[k] = !vld[k] || adv[k+1];
    end
  end

  assign s_tready = adv[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv[0]) begin
        vld[0] <= s_tvalid;
      end
      for (int k = 1; k < STAGES; k++) begin
        if (adv[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      in_data <= s_tdata[IN_BITS-1:0];
    end
  end

  srint_prep #(
    .COORD_BITS(COORD_BITS)
  ) u_prep (
    .clk         (clk),
    .en          (adv[1]),
    .rect_left   (signed'(in_data[TOP_LO-1:0])),
    .rect_top    (signed'(in_data[WID_LO-1:TOP_LO])),
    .rect_width  (in_data[HGT_LO-1:WID_LO]),
    .rect_height (in_data[SX_LO-1:HGT_LO]),
    .start_x     (signed'(in_data[SY_LO-1:SX_LO])),
    .start_y     (signed'(in_data[EX_LO-1:SY_LO])),
    .end_x       (signed'(in_data[EY_LO-1:EX_LO])),
    .end_y       (signed'(in_data[IN_BITS-1:EY_LO])),
    .op_a        (op_a),
    .op_b        (op_b),
    .op_c        (op_c),
    .op_d        (op_d),
    .inside_start(inside_start),
    .inside_end  (inside_end)
  );

  assign cen.prod = adv[2];
  assign cen.sign = adv[3];

  for (genvar u = 0; u < CROSS_UNITS; u++) begin : g_cross
    srint_cross #(
      .COORD_BITS(COORD_BITS)
    ) u_cross (
      .clk(clk),
      .en (cen),
      .a  (op_a[u]),
      .b  (op_b[u]),
      .c  (op_c[u]),
      .d  (op_d[u]),
      .sg (sg[u])
    );
  end

  // The inside flags travel alongside the products and signs.
  always_ff @(posedge clk) begin
    if (adv[2]) begin
      inside_p <= {inside_end, inside_start};
    end
    if (adv[3]) begin
      inside_s <= inside_p;
    end
  end

  // Strictly opposite signs: both nonzero and of different sign.
  function automatic logic opposite(input sign_t s, input sign_t q);
    opposite = !s.zero && !q.zero && (s.neg != q.neg);
  endfunction

  // A diagonal is crossed when the diagonal ends lie on opposite sides of
  // the segment and the segment ends lie on opposite sides of the diagonal.
  assign cross_main = opposite(sg[0], sg[1]) && opposite(sg[2], sg[3]);
  assign cross_anti = opposite(sg[4], sg[5]) && opposite(sg[6], sg[7]);

  always_ff @(posedge clk) begin
    if (adv[4]) begin
      hit <= (|inside_s) || cross_main || cross_anti;
    end
  end

  assign m_tvalid = vld[STAGES-1];
  assign m_tdata  = {{(OUT_W - 1){1'b0}}, hit};

endmodule

`default_nettype wire

/* tb/sv/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
  import srint_pkg::*;

  localparam int CB     = COORD_BITS_DEFAULT;
  localparam int IN_W   = ((8 * CB - 2 + 7) / 8) * 8;
  localparam int CMAX   = (1 << (CB - 1)) - 1;
  localparam int CMIN   = -(1 << (CB - 1));
  localparam int ONE    = 256;     // one whole unit with 8 fraction bits
  localparam int RANDOM_ITEMS = 900;
  localparam int HOLD_CYCLES  = 400;
  localparam int LIMIT  = 200000;
  localparam int IDLE_PCT = 35;

  // One geometry query as it travels on the input stream.
  typedef struct {
    logic signed [CB-1:0] rect_left;
    logic signed [CB-1:0] rect_top;
    logic [CB-2:0]        rect_width;
    logic [CB-2:0]        rect_height;
    logic signed [CB-1:0] start_x;
    logic signed [CB-1:0] start_y;
    logic signed [CB-1:0] end_x;
    logic signed [CB-1:0] end_y;
  } query_t;

  typedef struct {
    bit hit;
    int index;
  } pending_hit_t;

  // Keeps the hit flags still owed by the block, in order, and compares each
  // returned flag against the oldest one.
  class hit_scoreboard;
    pending_hit_t owed_hits[$];
    int queries_noted;
    int hits_noted;
    int errors;
    int reported;

    // Sign of (q - o) x (p - o); every term fits easily in 64 bits.
    function int turn_sign(longint ox, longint oy, longint px, longint py,
                           longint qx, longint qy);
      longint d;
      d = (qx - ox) * (py - oy) - (qy - oy) * (px - ox);
      return (d > 0) ? 1 : ((d < 0) ? -1 : 0);
    endfunction

    // Proper crossing only: both pairs of signs strictly opposite.
    function bit crosses(longint ax, longint ay, longint bx, longint by,
                         longint cx, longint cy, longint dx, longint dy);
      int s1, s2, s3, s4;
      s1 = turn_sign(ax, ay, bx, by, cx, cy);
      s2 = turn_sign(ax, ay, bx, by, dx, dy);
      s3 = turn_sign(cx, cy, dx, dy, ax, ay);
      s4 = turn_sign(cx, cy, dx, dy, bx, by);
      return (s1 * s2 < 0) && (s3 * s4 < 0);
    endfunction

    function bit strictly_in(longint px, longint py, longint l, longint t,
                             longint r, longint b);
      return px > l && px < r && py > t && py < b;
    endfunction

    // The right and bottom edges are kept at full width, so a rectangle that
    // runs past the coordinate range does not wrap.
    function bit compute_hit(query_t q);
      longint l, t, r, b, sx, sy, ex, ey;
      l  = longint'(q.rect_left);
      t  = longint'(q.rect_top);
      r  = l + longint'(q.rect_width);
      b  = t + longint'(q.rect_height);
      sx = longint'(q.start_x);
      sy = longint'(q.start_y);
      ex = longint'(q.end_x);
      ey = longint'(q.end_y);
      return strictly_in(sx, sy, l, t, r, b) || strictly_in(ex, ey, l, t, r, b)
          || crosses(sx, sy, ex, ey, l, t, r, b)
          || crosses(sx, sy, ex, ey, r, t, l, b);
    endfunction

    function void note_query(query_t q);
      pending_hit_t p;
      p.hit = compute_hit(q);
      p.index = queries_noted;
      queries_noted++;
      hits_noted += int'(p.hit);
      owed_hits.push_back(p);
    endfunction

    function void check_hit(bit got);
      pending_hit_t p;
      if (owed_hits.size() == 0) begin
        errors++;
        if (reported < 10) begin
          reported++;
          $display("[%0t] unexpected result item: hit=%0b", $time, got);
        end
        return;
      end
      p = owed_hits.pop_front();
      if (p.hit != got) begin
        errors++;
        if (reported < 10) begin
          reported++;
          $display("[%0t] query %0d: hit expected %0b, actual %0b",
                   $time, p.index, p.hit, got);
        end
      end
    endfunction

    function int pending();
      return owed_hits.size();
    endfunction
  endclass

  logic            clk;
  logic            rst;
  logic            s_tvalid;
  logic            s_tready;
  // from bit 0 up: rect_left, rect_top, rect_width, rect_height,
  // start_x, start_y, end_x, end_y, zero padding
  logic [IN_W-1:0] s_tdata;
  logic            m_tvalid;
  logic            m_tready;
  // from bit 0 up: hit, zero padding
  logic [OUT_W-1:0] m_tdata;

  hit_scoreboard sb = new();

  query_t offered;       // the query currently presented on s_tdata
  int     accepted = 0;  // input handshakes seen so far
  int     cycles = 0;
  bit     calm = 0;      // while set, neither side idles
  int     hold_req = 0;  // bumped to ask the receiver for a long hold-off
  int     hold_taken = 0;
  int     hold_left = 0;

  segment_rectangle_intersect #(.COORD_BITS(CB)) uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // Pack the fields back to back, first field in the lowest bits.
  function automatic logic [IN_W-1:0] pack_query(query_t q);
    return {{(IN_W - (8 * CB - 2)){1'b0}}, q.end_y, q.end_x, q.start_y,
            q.start_x, q.rect_height, q.rect_width, q.rect_top, q.rect_left};
  endfunction

  function automatic query_t make_query(int l, int t, int w, int h,
                                        int sx, int sy, int ex, int ey);
    query_t q;
    q.rect_left = CB'(l);
    q.rect_top = CB'(t);
    q.rect_width = (CB - 1)'(w);
    q.rect_height = (CB - 1)'(h);
    q.start_x = CB'(sx);
    q.start_y = CB'(sy);
    q.end_x = CB'(ex);
    q.end_y = CB'(ey);
    return q;
  endfunction

  // Range extremes, values next to zero or a uniform random value; truncated
  // to 23 bits the extremes also give the extremes of the size fields.
  function automatic int corner_value();
    case ($urandom_range(5))
      0: return CMIN;
      1: return CMAX;
      2: return 0;
      3: return -1;
      4: return 1;
      default: return int'($urandom);
    endcase
  endfunction

  // Random queries. Uniform values almost never land near the rectangle, so
  // most queries are built around a random rectangle: fine offsets for
  // general crossings, and whole-unit offsets so that endpoints often sit on
  // edges, corners and diagonal lines.
  function automatic query_t random_query();
    query_t q;
    int kind, step, span, bx, by;
    kind = $urandom_range(99);
    if (kind < 15) begin
      q = make_query($urandom, $urandom, $urandom, $urandom,
                     $urandom, $urandom, $urandom, $urandom);
    end else if (kind < 30) begin
      q = make_query(corner_value(), corner_value(), corner_value(),
                     corner_value(), corner_value(), corner_value(),
                     corner_value(), corner_value());
    end else begin
      step = (kind < 65) ? 1 : ONE;
      span = (kind < 65) ? 8192 : 6;
      bx = int'($urandom_range(16000000)) - 8000000;
      by = int'($urandom_range(16000000)) - 8000000;
      q = make_query(bx, by, step * $urandom_range(span), step * $urandom_range(span),
                     bx + step * (int'($urandom_range(2 * span)) - span / 2),
                     by + step * (int'($urandom_range(2 * span)) - span / 2),
                     bx + step * (int'($urandom_range(2 * span)) - span / 2),
                     by + step * (int'($urandom_range(2 * span)) - span / 2));
    end
    return q;
  endfunction

  // Present one query and hold it until the block takes it. Called at a
  // falling edge; returns at the falling edge after the handshake.
  task automatic send_query(query_t q);
    int seen;
    if (!calm && $urandom_range(99) < IDLE_PCT) begin
      s_tvalid = 1'b0;
      repeat ($urandom_range(3, 1)) @(negedge clk);
    end
    offered = q;
    s_tdata = pack_query(q);
    s_tvalid = 1'b1;
    seen = accepted;
    do @(negedge clk); while (accepted == seen);
  endtask

  // Receiver: random back-pressure, a calm stretch, and on request one long
  // hold-off that lets the pipeline fill and stall the input.
  initial begin
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (rst) begin
        m_tready = 1'b0;
      end else if (hold_left > 0) begin
        m_tready = 1'b0;
        hold_left--;
      end else if (hold_req != hold_taken) begin
        hold_taken = hold_req;
        hold_left = HOLD_CYCLES - 1;
        m_tready = 1'b0;
      end else begin
        m_tready = calm || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // Both handshakes are sampled at the rising edge. The result is checked
  // before the new query is noted; with the pipeline latency the two can
  // never belong to the same item anyway.
  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready)
        sb.check_hit(m_tdata[0]);
      if (s_tvalid && s_tready) begin
        sb.note_query(offered);
        accepted++;
      end
    end
    cycles++;
    if (cycles > LIMIT) begin
      $display("Timeout after %0d cycles, %0d results still owed", cycles, sb.pending());
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    query_t dq[$];
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    offered = make_query(0, 0, 0, 0, 0, 0, 0, 0);
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed queries around a 10 by 10 unit square at the origin unless
    // noted otherwise.
    dq.push_back(make_query(0, 0, 10*ONE, 10*ONE, 2*ONE, 2*ONE, 3*ONE, 3*ONE));
    dq.push_back(make_query(0, 0, 10*ONE, 10*ONE, 5*ONE, 5*ONE, 20*ONE, 20*ONE));
    dq.push_back(make_query(0, 0, 10*ONE, 10*ONE, 20*ONE, 3*ONE, 7*ONE, 2*ONE));
    // Endpoint on the left edge, segment outside.
    dq.push_back(make_query(0, 0, 10*ONE, 10*ONE, 0, 5*ONE, -5*ONE, 5*ONE));
    // Segment running along the top edge through a corner.
    dq.push_back(make_query(0, 0, 10*ONE, 10*ONE, -5*ONE, 0, 15*ONE, 0));
    // Straight through the middle.
    dq.push_back(make_query(0, 0, 10*ONE, 10*ONE, -5*ONE, 5*ONE, 15*ONE, 5*ONE));
    // On the extended diagonal but short of the square.
    dq.push_back(make_query(0, 0, 10*ONE, 10*ONE, -5*ONE, -5*ONE, -ONE, -ONE));
    // Along the whole main diagonal: collinear there, crosses the other one.
    dq.push_back(make_query(0, 0, 10*ONE, 10*ONE, -5*ONE, -5*ONE, 15*ONE, 15*ONE));
    // Touching a corner from outside.
    dq.push_back(make_query(0, 0, 10*ONE, 10*ONE, -5*ONE, -5*ONE, 0, 0));
    // Zero width or zero height: the diagonals lie on one line, a crossing still counts.
    dq.push_back(make_query(0, 0, 0, 10*ONE, -5*ONE, 5*ONE, 5*ONE, 5*ONE));
    dq.push_back(make_query(0, 0, 10*ONE, 0, 5*ONE, -5*ONE, 5*ONE, 5*ONE));
    // Zero width and height: never a hit.
    dq.push_back(make_query(0, 0, 0, 0, -5*ONE, -5*ONE, 5*ONE, 5*ONE));
    // Degenerate segments, inside and outside.
    dq.push_back(make_query(0, 0, 10*ONE, 10*ONE, 3*ONE, 3*ONE, 3*ONE, 3*ONE));
    dq.push_back(make_query(0, 0, 10*ONE, 10*ONE, 20*ONE, 20*ONE, 20*ONE, 20*ONE));
    // Negative coordinates with fractional endpoints.
    dq.push_back(make_query(-10*ONE, -10*ONE, 5*ONE, 5*ONE, -12*ONE, -7*ONE - 128,
                            -3*ONE, -8*ONE + 64));
    // One least step wide rectangle crossed at the fraction level.
    dq.push_back(make_query(1, 1, 1, 1, 0, 3, 3, 0));
    // Rectangle running far past the top of the range.
    dq.push_back(make_query(CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMIN, CMIN));
    dq.push_back(make_query(CMAX - 10, CMAX - 10, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX - 1));
    // Whole-range segments across a rectangle around the origin.
    dq.push_back(make_query(-ONE, -ONE, 2*ONE, 2*ONE, CMIN, CMIN, CMAX, CMAX));
    dq.push_back(make_query(-ONE, -ONE, 2*ONE, 2*ONE, CMIN, CMAX, CMAX, CMIN));
    // Largest rectangle from the bottom of the range.
    dq.push_back(make_query(CMIN, CMIN, CMAX, CMAX, CMIN, 0, 0, CMIN));
    // All fields at their lowest and at their highest.
    dq.push_back(make_query(CMIN, CMIN, 0, 0, CMIN, CMIN, CMIN, CMIN));
    dq.push_back(make_query(CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX));
    dq.push_back(make_query(-1, -1, CMAX, CMAX, -1, 0, 0, -1));
    foreach (dq[i])
      send_query(dq[i]);

    // Random part: a calm stretch in the first half and one long receiver
    // hold-off later, while queries keep coming.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      calm = (n >= 200 && n < 400);
      if (n == 550)
        hold_req++;
      send_query(random_query());
    end
    s_tvalid = 1'b0;
    calm = 1'b0;

    while (sb.pending() != 0)
      @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Checked %0d segment/rectangle queries (%0d hits, %0d misses), %0d mismatches",
             sb.queries_noted, sb.hits_noted, sb.queries_noted - sb.hits_noted, sb.errors);
    $display("Covered edge and corner contacts, degenerate shapes, range extremes, %0d-cycle stall",
             HOLD_CYCLES);
    if (sb.errors == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
